// File: rtl/core/lmx_pkg.sv
// shared types, widths and codes of the lamport mutex node
package lmx_pkg;

   localparam int MAX_NODES = 16;
   localparam int FILL_W    = $clog2(MAX_NODES + 1);

   localparam int CMD_W   = 3;
   localparam int NODE_W  = 4;
   localparam int TIME_W  = 15;
   localparam int COUNT_W = 5;
   localparam int REPLY_W = 5;
   localparam int KIND_W  = 2;
   localparam int PEND_W  = 5;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam logic [TIME_W-1:0]  CLOCK_MAX = '1;
   localparam logic [REPLY_W-1:0] REPLY_MAX = '1;

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOCAL_REQ = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOCAL_REL = 3'd1;
   localparam logic [CMD_W-1:0] CMD_GOT_REQ   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_GOT_REPLY = 3'd3;
   localparam logic [CMD_W-1:0] CMD_GOT_REL   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_GOT_DONE  = 3'd5;

   // outgoing message kinds
   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REPLY   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd3;

   // register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_NODE_ID    = 2'd0;
   localparam logic [1:0] REG_NODE_COUNT = 2'd1;
   localparam logic [1:0] REG_MUTEX_EN   = 2'd2;
   localparam logic [1:0] REG_DONE_FLAGS = 2'd3;

   typedef struct packed {
      logic [NODE_W-1:0]  node_id;
      logic [COUNT_W-1:0] node_count;
      logic               mutex_enable;
   } cfg_type;

   // controller to datapath step commands
   typedef struct packed {
      logic load;
      logic compare;
      logic apply;
      logic result;
   } dp_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MATCH  = 4'b0010,
      ST_SHIFT  = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

endpackage

// File: rtl/core/lmx_csr.sv
// apb-style configuration registers of the lamport mutex node
module lmx_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [lmx_pkg::ADDR_W-1:0]  paddr,
   input  logic [lmx_pkg::DATA_W-1:0]  pwdata,
   output logic [lmx_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   input  logic [lmx_pkg::MAX_NODES-1:0] done_flags,
   output lmx_pkg::cfg_type            cfg
);
   import lmx_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_NODE_ID:    cfg_in.node_id      = pwdata[NODE_W-1:0];
            REG_NODE_COUNT: cfg_in.node_count   = pwdata[COUNT_W-1:0];
            REG_MUTEX_EN:   cfg_in.mutex_enable = pwdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_id      <= NODE_W'(1);
         cfg_ff.node_count   <= COUNT_W'(2);
         cfg_ff.mutex_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_NODE_ID:    prdata = DATA_W'(cfg_ff.node_id);
         REG_NODE_COUNT: prdata = DATA_W'(cfg_ff.node_count);
         REG_MUTEX_EN:   prdata = DATA_W'(cfg_ff.mutex_enable);
         REG_DONE_FLAGS: prdata = DATA_W'(done_flags);
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/lmx_ctrl.sv
// sequencing state machine and result handshake of the lamport mutex node
module lmx_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lmx_pkg::dp_cmd_type ctl
);
   import lmx_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in    = state_ff;
      ctl         = '0;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            ctl.compare = 1'b1;
            state_in    = ST_SHIFT;
         end
         ST_SHIFT: begin
            ctl.apply = 1'b1;
            state_in  = ST_RESULT;
         end
         ST_RESULT: begin
            // hold here while the previous result is still waiting
            if (out_free) begin
               ctl.result = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/core/lmx_datapath.sv
// lamport clock, sorted request queue, reply count, done flags and result register
module lmx_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  lmx_pkg::dp_cmd_type           ctl,
   input  lmx_pkg::cfg_type              cfg,
   input  logic [lmx_pkg::CMD_W-1:0]     req_command,
   input  logic [lmx_pkg::NODE_W-1:0]    req_peer_id,
   input  logic [lmx_pkg::TIME_W-1:0]    req_msg_time,
   output logic [lmx_pkg::KIND_W-1:0]    rsp_send_kind,
   output logic [lmx_pkg::NODE_W-1:0]    rsp_send_dest,
   output logic [lmx_pkg::TIME_W-1:0]    rsp_send_time,
   output logic                          rsp_granted,
   output logic [lmx_pkg::PEND_W-1:0]    rsp_pending_count,
   output logic [lmx_pkg::MAX_NODES-1:0] done_flags
);
   import lmx_pkg::*;

   function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] value);
      sat_inc = (value == CLOCK_MAX) ? value : value + 1'b1;
   endfunction

   logic [CMD_W-1:0]     cmd_ff;
   logic [NODE_W-1:0]    peer_ff;
   logic [TIME_W-1:0]    mtime_ff;
   logic [TIME_W-1:0]    clock_ff, clock_in;
   logic [TIME_W-1:0]    stamp_ff [MAX_NODES];
   logic [TIME_W-1:0]    stamp_in [MAX_NODES];
   logic [NODE_W-1:0]    node_ff  [MAX_NODES];
   logic [NODE_W-1:0]    node_in  [MAX_NODES];
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [REPLY_W-1:0]   replies_ff, replies_in;
   logic [MAX_NODES-1:0] flags_ff, flags_in;
   logic [MAX_NODES-1:0] hit_ff, hit_in;
   logic [MAX_NODES-1:0] shift_up;

   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [NODE_W-1:0]    dest_ff, dest_in;
   logic [TIME_W-1:0]    stime_ff, stime_in;
   logic                 grant_ff, grant_in;
   logic [PEND_W-1:0]    pend_ff, pend_in;

   logic                 is_lreq, is_lrel, is_greq, is_grel;
   logic                 do_insert, do_remove, queue_full, found;
   logic [TIME_W-1:0]    key_stamp;
   logic [NODE_W-1:0]    key_node;
   logic [COUNT_W-1:0]   expected;

   assign is_lreq    = (cmd_ff == CMD_LOCAL_REQ) & cfg.mutex_enable;
   assign is_lrel    = (cmd_ff == CMD_LOCAL_REL) & cfg.mutex_enable;
   assign is_greq    = (cmd_ff == CMD_GOT_REQ);
   assign is_grel    = (cmd_ff == CMD_GOT_REL);
   assign do_insert  = is_lreq | is_greq;
   assign do_remove  = is_lrel | is_grel;
   assign key_stamp  = is_lreq ? clock_ff : mtime_ff;
   assign key_node   = (is_lreq | is_lrel) ? cfg.node_id : peer_ff;
   assign queue_full = (fill_ff == FILL_W'(MAX_NODES));
   assign found      = |hit_ff;
   assign expected   = (cfg.node_count >= COUNT_W'(2)) ?
                       cfg.node_count - COUNT_W'(2) : '0;

   // per-entry compare: after-key for insert, node match for remove
   always_comb begin
      for (int k = 0; k < MAX_NODES; k++) begin
         logic valid;
         logic later;
         valid = FILL_W'(k) < fill_ff;
         later = (stamp_ff[k] > key_stamp) ||
                 ((stamp_ff[k] == key_stamp) && (node_ff[k] > key_node));
         hit_in[k] = valid & (do_insert ? later : (node_ff[k] == key_node));
      end
   end

   // entries at or past the first match move down on remove
   always_comb begin
      for (int k = 0; k < MAX_NODES; k++) begin
         shift_up[k] = |(hit_ff & ({MAX_NODES{1'b1}} >> (MAX_NODES - 1 - k)));
      end
   end

   always_comb begin
      clock_in   = clock_ff;
      fill_in    = fill_ff;
      replies_in = replies_ff;
      flags_in   = flags_ff;
      for (int k = 0; k < MAX_NODES; k++) begin
         stamp_in[k] = stamp_ff[k];
         node_in[k]  = node_ff[k];
      end

      if (ctl.load) begin
         if (req_command == CMD_LOCAL_REQ) begin
            if (cfg.mutex_enable) begin
               clock_in = sat_inc(clock_ff);
            end
         end else if (req_command == CMD_GOT_REQ || req_command == CMD_GOT_REPLY ||
                      req_command == CMD_GOT_REL || req_command == CMD_GOT_DONE) begin
            clock_in = sat_inc((req_msg_time > clock_ff) ? req_msg_time : clock_ff);
         end
      end

      if (ctl.apply) begin
         if (is_lrel || is_greq) begin
            clock_in = sat_inc(clock_ff);
         end
         if (is_lreq) begin
            replies_in = '0;
         end else if (cmd_ff == CMD_GOT_REPLY && replies_ff != REPLY_MAX) begin
            replies_in = replies_ff + 1'b1;
         end
         if (cmd_ff == CMD_GOT_DONE) begin
            for (int k = 0; k < MAX_NODES; k++) begin
               if (int'(peer_ff) == k) begin
                  flags_in[k] = 1'b1;
               end
            end
         end

         if (do_insert && !queue_full) begin
            fill_in = fill_ff + 1'b1;
            if (hit_ff[0] || fill_ff == '0) begin
               stamp_in[0] = key_stamp;
               node_in[0]  = key_node;
            end
            for (int k = 1; k < MAX_NODES; k++) begin
               if (hit_ff[k-1]) begin
                  stamp_in[k] = stamp_ff[k-1];
                  node_in[k]  = node_ff[k-1];
               end else if (hit_ff[k] || fill_ff == FILL_W'(k)) begin
                  stamp_in[k] = key_stamp;
                  node_in[k]  = key_node;
               end
            end
         end else if (do_remove && found) begin
            fill_in = fill_ff - 1'b1;
            for (int k = 0; k < MAX_NODES - 1; k++) begin
               if (shift_up[k]) begin
                  stamp_in[k] = stamp_ff[k+1];
                  node_in[k]  = node_ff[k+1];
               end
            end
         end
      end
   end

   // result from the state left by this transaction
   always_comb begin
      kind_in  = KIND_NONE;
      dest_in  = '0;
      if (is_lreq) begin
         kind_in = KIND_REQUEST;
      end else if (is_lrel) begin
         kind_in = KIND_RELEASE;
      end else if (is_greq) begin
         kind_in = KIND_REPLY;
         dest_in = peer_ff;
      end
      stime_in = (kind_in == KIND_NONE) ? '0 : clock_ff;
      if (cfg.mutex_enable) begin
         grant_in = (fill_ff != '0) && (node_ff[0] == cfg.node_id) &&
                    (replies_ff >= expected);
      end else begin
         grant_in = (cmd_ff == CMD_LOCAL_REQ);
      end
      pend_in = (int'(fill_ff) > 31) ? PEND_W'(31) : PEND_W'(fill_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff   <= '0;
         fill_ff    <= '0;
         replies_ff <= '0;
         flags_ff   <= '0;
      end else begin
         clock_ff   <= clock_in;
         fill_ff    <= fill_in;
         replies_ff <= replies_in;
         flags_ff   <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_NODES; k++) begin
         stamp_ff[k] <= stamp_in[k];
         node_ff[k]  <= node_in[k];
      end
      if (ctl.load) begin
         cmd_ff   <= req_command;
         peer_ff  <= req_peer_id;
         mtime_ff <= req_msg_time;
      end
      if (ctl.compare) begin
         hit_ff <= hit_in;
      end
      if (ctl.result) begin
         kind_ff  <= kind_in;
         dest_ff  <= dest_in;
         stime_ff <= stime_in;
         grant_ff <= grant_in;
         pend_ff  <= pend_in;
      end
   end

   assign rsp_send_kind     = kind_ff;
   assign rsp_send_dest     = dest_ff;
   assign rsp_send_time     = stime_ff;
   assign rsp_granted       = grant_ff;
   assign rsp_pending_count = pend_ff;
   assign done_flags        = flags_ff;

endmodule

// File: rtl/core/lamport_mutex_node.sv
// top level of one lamport mutual exclusion node
//
// Each transaction runs through these steps in order: the accept step updates
// the lamport clock, the next compares every queue entry against the key in
// parallel, the third shifts the sorted queue and updates the reply count
// and done flags, and the fourth loads the result register. That
// compare-then-shift sequence over the request queue sets the rate. The
// result register holds a finished result while the next request is taken;
// the fourth step stalls only while the previous result is still unread.
// Registers: node_id at 0x0, node_count at 0x4, mutex_enable at 0x8, and a
// read-only view of the done flags at 0xC; write them only while idle.
module lamport_mutex_node (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [lmx_pkg::CMD_W-1:0]   req_command,
   input  logic [lmx_pkg::NODE_W-1:0]  req_peer_id,
   input  logic [lmx_pkg::TIME_W-1:0]  req_msg_time,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [lmx_pkg::KIND_W-1:0]  rsp_send_kind,
   output logic [lmx_pkg::NODE_W-1:0]  rsp_send_dest,
   output logic [lmx_pkg::TIME_W-1:0]  rsp_send_time,
   output logic                        rsp_granted,
   output logic [lmx_pkg::PEND_W-1:0]  rsp_pending_count,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [lmx_pkg::ADDR_W-1:0]  paddr,
   input  logic [lmx_pkg::DATA_W-1:0]  pwdata,
   output logic [lmx_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import lmx_pkg::*;

   cfg_type              cfg;
   dp_cmd_type           ctl;
   logic [MAX_NODES-1:0] done_flags;

   lmx_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .done_flags (done_flags),
      .cfg        (cfg)
   );

   lmx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl)
   );

   lmx_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .cfg               (cfg),
      .req_command       (req_command),
      .req_peer_id       (req_peer_id),
      .req_msg_time      (req_msg_time),
      .rsp_send_kind     (rsp_send_kind),
      .rsp_send_dest     (rsp_send_dest),
      .rsp_send_time     (rsp_send_time),
      .rsp_granted       (rsp_granted),
      .rsp_pending_count (rsp_pending_count),
      .done_flags        (done_flags)
   );

endmodule

// File: rtl/core/lmx_checker.sv
// port-level assertions of the lamport mutex node and their bind
module lmx_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [lmx_pkg::KIND_W-1:0]  rsp_send_kind,
   input logic [lmx_pkg::NODE_W-1:0]  rsp_send_dest,
   input logic [lmx_pkg::TIME_W-1:0]  rsp_send_time,
   input logic [lmx_pkg::PEND_W-1:0]  rsp_pending_count
);
   import lmx_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result transaction dropped before it was taken");

   a_silent_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_kind == KIND_NONE |-> rsp_send_time == '0)
      else $error("time given with no outgoing message");

   a_dest_reply_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_kind != KIND_REPLY |-> rsp_send_dest == '0)
      else $error("destination given on a message that is not a reply");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_pending_count) <= MAX_NODES)
      else $error("request queue reported beyond its depth");

endmodule

bind lamport_mutex_node lmx_checker u_lmx_checker (.*);
